### design/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants of the file type sniffer
// Verdict codes, the magic prefix table and the control bundle that the top
// level hands to the UTF-8 checker.
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int HEADER_BYTES_DEFAULT = 512;
	localparam int NUM_MAGIC = 6;
	localparam int MAGIC_MAX = 14;
	localparam int MAGIC_IDX_W = $clog2(MAGIC_MAX);

	typedef enum logic [2:0] {
		FT_UNKNOWN = 3'd0,
		FT_ZIP     = 3'd1,
		FT_BZIP2   = 3'd2,
		FT_GZIP    = 3'd3,
		FT_XML     = 3'd4,
		FT_UTF8    = 3'd5
	} file_type_t;

	localparam logic [7:0] MAGIC_TEXT [NUM_MAGIC][MAGIC_MAX] = '{
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59,
		  8'h50, 8'h45, 8'h20, 8'h68, 8'h74, 8'h6D, 8'h6C}
	};

	localparam int MAGIC_LEN [NUM_MAGIC] = '{4, 3, 3, 5, 5, 14};

	localparam file_type_t MAGIC_TYPE [NUM_MAGIC] = '{
		FT_ZIP, FT_BZIP2, FT_GZIP, FT_XML, FT_XML, FT_XML
	};

	// Control for the UTF-8 checker: step examines the byte, clear ends the file.
	typedef struct packed {
		logic step;
		logic clear;
	} utf8_ctl_t;

endpackage
`default_nettype wire

### design/fts_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fts_utf8: lax UTF-8 checker
// Tracks lead and follower bytes and reports whether the text test has failed,
// including the effect of the byte being examined in this cycle.
// ----------------------------------------------------------------------------
module fts_utf8 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fts_pkg::utf8_ctl_t ctl,
	input  wire logic [7:0]        data,
	output logic                   rejected_next
);
	import fts_pkg::*;

	logic [1:0] pend_q;
	logic       bad_q;
	logic       rej_q;
	logic [1:0] pend_d;
	logic       bad_d;
	logic       rej_d;
	logic       bad_any;

	always_comb begin
		pend_d  = pend_q;
		bad_d   = bad_q;
		rej_d   = rej_q;
		bad_any = bad_q | (data[7:6] == 2'b11);
		if (!rej_q) begin
			if (pend_q != 2'd0) begin
				pend_d = pend_q - 2'd1;
				// A bad follower only counts once the sequence is complete.
				if (pend_d == 2'd0 && bad_any) begin
					rej_d = 1'b1;
					bad_d = 1'b0;
				end else begin
					bad_d = bad_any;
				end
			end else begin
				bad_d = 1'b0;
				priority if (data[7] == 1'b0) begin
					pend_d = 2'd0;
				end else if (data[7:3] == 5'b11111) begin
					rej_d = 1'b1;
				end else if (data[7:4] == 4'b1111) begin
					pend_d = 2'd3;
				end else if (data[7:5] == 3'b111) begin
					pend_d = 2'd2;
				end else if (data[7:6] == 2'b11) begin
					pend_d = 2'd1;
				end else begin
					// A stray continuation byte passes as text.
					pend_d = 2'd0;
				end
			end
		end
	end

	assign rejected_next = ctl.step ? rej_d : rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			bad_q  <= 1'b0;
			rej_q  <= 1'b0;
		end else if (ctl.clear) begin
			pend_q <= 2'd0;
			bad_q  <= 1'b0;
			rej_q  <= 1'b0;
		end else if (ctl.step) begin
			pend_q <= pend_d;
			bad_q  <= bad_d;
			rej_q  <= rej_d;
		end
	end

endmodule
`default_nettype wire

### design/file_type_sniffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// file_type_sniffer: magic number and UTF-8 content sniffer
// Streams a file one byte per transfer and gives one verdict on the last byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle: a byte sits in the input register,
// where the prefix compares and the UTF-8 checker update the file state,
// and the verdict of the byte marked last lands in the result register as
// that byte leaves the input register. A result thus follows its last byte
// through the input and result registers, and bytes keep flowing while it
// waits; only a last byte stalls while an earlier verdict has not been taken.
// Only the first HEADER_BYTES bytes are examined; later bytes are accepted
// and ignored until the last one. State returns to reset values after every verdict.
module file_type_sniffer #(
	parameter int HEADER_BYTES = fts_pkg::HEADER_BYTES_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          data_byte,
	input  wire logic                last_byte,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               content_kind
);
	import fts_pkg::*;

	localparam int POS_W = $clog2(HEADER_BYTES + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [POS_W-1:0]  pos_q;
	logic [NUM_MAGIC-1:0] alive_q;
	logic              out_valid_q;
	file_type_t        content_kind_q;

	logic              out_free;
	logic              s1_go;
	logic              in_hdr;
	logic [POS_W-1:0]  pos_d;
	logic [NUM_MAGIC-1:0] alive_d;
	logic              text_rej;
	file_type_t        verdict;
	logic              found;
	utf8_ctl_t         utf8_ctl;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;

	assign in_hdr = pos_q < POS_W'(HEADER_BYTES);
	assign pos_d  = in_hdr ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		alive_d = alive_q;
		if (in_hdr) begin
			for (int k = 0; k < NUM_MAGIC; k++) begin
				if (pos_q < POS_W'(MAGIC_LEN[k]) &&
				    byte_s1 != MAGIC_TEXT[k][pos_q[MAGIC_IDX_W-1:0]]) begin
					alive_d[k] = 1'b0;
				end
			end
		end
	end

	assign utf8_ctl.step  = s1_go && in_hdr;
	assign utf8_ctl.clear = s1_go && last_s1;

	fts_utf8 u_utf8 (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (utf8_ctl),
		.data          (byte_s1),
		.rejected_next (text_rej)
	);

	// The first complete prefix in table order wins over the text test.
	always_comb begin
		verdict = text_rej ? FT_UNKNOWN : FT_UTF8;
		found   = 1'b0;
		for (int k = 0; k < NUM_MAGIC; k++) begin
			if (!found && alive_d[k] && pos_d >= POS_W'(MAGIC_LEN[k])) begin
				verdict = MAGIC_TYPE[k];
				found   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_q       <= '0;
			alive_q     <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				if (last_s1) begin
					pos_q   <= '0;
					alive_q <= '1;
				end else begin
					pos_q   <= pos_d;
					alive_q <= alive_d;
				end
			end
			if (s1_go && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (s1_go && last_s1) begin
			content_kind_q <= verdict;
		end
	end

	assign out_valid    = out_valid_q;
	assign content_kind = content_kind_q;

endmodule
`default_nettype wire
